[sv/skf_pkg.sv]
package skf_pkg;

	localparam int FRAC_BITS_DEF  = 16;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int REG_IDX_W      = 3;

	// configuration register indexes
	typedef enum logic [REG_IDX_W-1:0] {
		REG_INIT_EST = 3'd0,
		REG_INIT_VAR = 3'd1,
		REG_PNOISE   = 3'd2,
		REG_MNOISE   = 3'd3,
		REG_TRANS    = 3'd4,
		REG_OBS      = 3'd5
	} reg_idx_t;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_LOAD = 6'b000010,
		S_MUL  = 6'b000100,
		S_DIV  = 6'b001000,
		S_POST = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	// sequencer steps, run in this order for every item
	typedef enum logic [3:0] {
		OP_XP   = 4'd0,
		OP_A2   = 4'd1,
		OP_PP   = 4'd2,
		OP_PH   = 4'd3,
		OP_DEN  = 4'd4,
		OP_DIV  = 4'd5,
		OP_HX   = 4'd6,
		OP_CORR = 4'd7,
		OP_GH   = 4'd8,
		OP_PN   = 4'd9
	} op_t;

endpackage

[sv/scalar_kalman_filter_core.sv]
// scalar kalman filter, one measurement in, one (estimate, variance) pair out.
// input channel s_t*: one item carries a signed fixed point measurement.
// output channel m_t*: one item carries the new estimate and the new variance,
// which also become the filter state for the next measurement.
// config port cfg_*: writes registers 0..5 (initial estimate, initial variance,
// process noise, measurement noise, transition coef, observation coef); a write
// to register 0 or 1 reloads the state from both initial registers. write only
// while no item is in flight.
// each item runs nine bit-serial shift-add multiplies and one restoring divide,
// each with a load step before it and a post step after it.
// one item is worked on at a time; s_tready is high only between items, and
// the next item may be accepted while the last result still waits in the
// output register. if the receiver stalls, the finished result of the next
// item holds until the output register frees up.
// reset (arst_n low) loads the register defaults and the initial state and
// empties the output register.
module scalar_kalman_filter_core #(
	parameter int FRAC_BITS  = skf_pkg::FRAC_BITS_DEF,
	parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [((DATA_WIDTH+7)/8)*8-1:0]        s_tdata,   // measurement
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [((2*DATA_WIDTH+7)/8)*8-1:0]      m_tdata,   // filtered_estimate, error_variance
	input  logic                                   cfg_we,
	input  logic [skf_pkg::REG_IDX_W-1:0]          cfg_idx,
	input  logic [DATA_WIDTH-1:0]                  cfg_data
);

	localparam int W     = DATA_WIDTH;
	localparam int F     = FRAC_BITS;
	localparam int OUT_W = ((2*DATA_WIDTH+7)/8)*8;
	localparam int CNT_W = $clog2(W+F+1);

	localparam logic [W-1:0] ONE_V   = {{(W-F-1){1'b0}}, 1'b1, {F{1'b0}}};
	localparam logic [W-1:0] UMAX    = {W{1'b1}};
	localparam logic [W-1:0] SMAX    = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] SMINMAG = {1'b1, {(W-1){1'b0}}};
	localparam longint unsigned ONE_L = 64'd1 << F;
	localparam logic [W-1:0] Q_RST   = W'((ONE_L + 64'd5) / 64'd10);
	localparam logic [W-1:0] R_RST   = W'(64'd400 << F);

	function automatic logic [W-1:0] mag_f(input logic [W-1:0] v);
		return v[W-1] ? (~v + 1'b1) : v;
	endfunction

	function automatic logic [W-1:0] sat_f(input logic [W:0] v);
		logic [W-1:0] r;
		if (v[W] != v[W-1]) begin
			r = v[W] ? SMINMAG : SMAX;
		end else begin
			r = v[W-1:0];
		end
		return r;
	endfunction

	skf_pkg::state_t state_q;
	skf_pkg::op_t    op_q;
	logic [CNT_W-1:0] cnt_q;
	logic             m_tvalid_q;

	logic [W-1:0] init_est_q, init_var_q, pnoise_q, mnoise_q, trans_q, obs_q;
	logic [W-1:0] est_q, var_q;

	logic [W-1:0] z_q, xp_q, a2_q, pp_q, ph_q, den_q, g_q, innov_q, fac_q;
	logic [W-1:0] out_est_q, out_var_q;

	// shift-add multiplier: multiplier bits enter at the low end of prod_q
	logic [W-1:0]   mcand_q;
	logic [2*W-1:0] prod_q;
	logic           neg_q;
	logic           ucap_q;

	// restoring divider
	logic [W-1:0]   rem_q;
	logic [W+F-1:0] dvd_q;
	logic [W-1:0]   quo_q;
	logic           over_q;

	logic [W-1:0] ld_a, ld_b;
	logic         ld_neg, ld_u;

	logic [W:0]       mul_sum;
	logic [2*W-F-1:0] shr;
	logic [W-1:0]     cap, mres, sres, usat, gmag;
	logic             pover;
	logic [W:0]       usum, innov_w, est_w, fac_w;
	logic             fac_pos;
	logic [W:0]       rem_sh, rem_sub;
	logic             ge;

	always_comb begin
		unique case (op_q)
			skf_pkg::OP_XP: begin
				ld_a = mag_f(trans_q); ld_b = mag_f(est_q);
				ld_neg = trans_q[W-1] ^ est_q[W-1]; ld_u = 1'b0;
			end
			skf_pkg::OP_A2: begin
				ld_a = mag_f(trans_q); ld_b = mag_f(trans_q); ld_neg = 1'b0; ld_u = 1'b1;
			end
			skf_pkg::OP_PP: begin
				ld_a = a2_q; ld_b = var_q; ld_neg = 1'b0; ld_u = 1'b1;
			end
			skf_pkg::OP_PH: begin
				ld_a = pp_q; ld_b = mag_f(obs_q); ld_neg = 1'b0; ld_u = 1'b1;
			end
			skf_pkg::OP_DEN: begin
				ld_a = ph_q; ld_b = mag_f(obs_q); ld_neg = 1'b0; ld_u = 1'b1;
			end
			skf_pkg::OP_HX: begin
				ld_a = mag_f(obs_q); ld_b = mag_f(xp_q);
				ld_neg = obs_q[W-1] ^ xp_q[W-1]; ld_u = 1'b0;
			end
			skf_pkg::OP_CORR: begin
				ld_a = g_q; ld_b = mag_f(innov_q);
				ld_neg = obs_q[W-1] ^ innov_q[W-1]; ld_u = 1'b0;
			end
			// gain carries the sign of h, so gain*h is never negative
			skf_pkg::OP_GH: begin
				ld_a = g_q; ld_b = mag_f(obs_q); ld_neg = 1'b0; ld_u = 1'b0;
			end
			skf_pkg::OP_PN: begin
				ld_a = fac_q; ld_b = pp_q; ld_neg = 1'b0; ld_u = 1'b1;
			end
			default: begin
				ld_a = '0; ld_b = '0; ld_neg = 1'b0; ld_u = 1'b1;
			end
		endcase
	end

	assign mul_sum = {1'b0, prod_q[2*W-1:W]} + {1'b0, (prod_q[0] ? mcand_q : {W{1'b0}})};

	assign shr   = prod_q[2*W-1:F];
	assign cap   = ucap_q ? UMAX : (neg_q ? SMINMAG : SMAX);
	assign pover = shr > {{(W-F){1'b0}}, cap};
	assign mres  = pover ? cap : shr[W-1:0];
	assign sres  = neg_q ? (~mres + 1'b1) : mres;

	assign usum    = {1'b0, mres} + {1'b0, ((op_q == skf_pkg::OP_PP) ? pnoise_q : mnoise_q)};
	assign usat    = usum[W] ? UMAX : usum[W-1:0];
	assign innov_w = {z_q[W-1], z_q} - {sres[W-1], sres};
	assign est_w   = {xp_q[W-1], xp_q} + {sres[W-1], sres};
	assign fac_w   = {1'b0, ONE_V} - {sres[W-1], sres};
	assign fac_pos = !fac_w[W] && (fac_w != '0);

	assign rem_sh  = {rem_q, dvd_q[W+F-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign gmag    = (den_q == '0) ? '0 : ((over_q || quo_q[W-1]) ? SMAX : quo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= skf_pkg::S_IDLE;
			op_q       <= skf_pkg::OP_XP;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
			init_est_q <= '0;
			init_var_q <= ONE_V;
			pnoise_q   <= Q_RST;
			mnoise_q   <= R_RST;
			trans_q    <= ONE_V;
			obs_q      <= ONE_V;
			est_q      <= '0;
			var_q      <= ONE_V;
		end else begin
			// a result finishing this cycle refills the output register instead
			if (m_tvalid_q && m_tready && state_q != skf_pkg::S_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (skf_pkg::reg_idx_t'(cfg_idx))
					skf_pkg::REG_INIT_EST: begin
						init_est_q <= cfg_data;
						est_q      <= cfg_data;
						var_q      <= init_var_q;
					end
					skf_pkg::REG_INIT_VAR: begin
						init_var_q <= cfg_data;
						var_q      <= cfg_data;
						est_q      <= init_est_q;
					end
					skf_pkg::REG_PNOISE: pnoise_q <= cfg_data;
					skf_pkg::REG_MNOISE: mnoise_q <= cfg_data;
					skf_pkg::REG_TRANS:  trans_q  <= cfg_data;
					skf_pkg::REG_OBS:    obs_q    <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				skf_pkg::S_IDLE: if (s_tvalid) begin
					state_q <= skf_pkg::S_LOAD;
					op_q    <= skf_pkg::OP_XP;
				end
				skf_pkg::S_LOAD: begin
					if (op_q == skf_pkg::OP_DIV) begin
						cnt_q   <= CNT_W'(W + F);
						state_q <= skf_pkg::S_DIV;
					end else begin
						cnt_q   <= CNT_W'(W);
						state_q <= skf_pkg::S_MUL;
					end
				end
				skf_pkg::S_MUL, skf_pkg::S_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						state_q <= skf_pkg::S_POST;
					end
				end
				skf_pkg::S_POST: begin
					unique case (op_q)
						skf_pkg::OP_CORR: est_q <= sat_f(est_w);
						skf_pkg::OP_PN:   var_q <= mres;
						default: ;
					endcase
					if (op_q == skf_pkg::OP_PN) begin
						state_q <= skf_pkg::S_OUT;
					end else begin
						op_q    <= skf_pkg::op_t'(op_q + 1'b1);
						state_q <= skf_pkg::S_LOAD;
					end
				end
				skf_pkg::S_OUT: if (!m_tvalid_q || m_tready) begin
					m_tvalid_q <= 1'b1;
					state_q    <= skf_pkg::S_IDLE;
				end
				default: state_q <= skf_pkg::S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			skf_pkg::S_IDLE: if (s_tvalid) begin
				z_q <= s_tdata[W-1:0];
			end
			skf_pkg::S_LOAD: begin
				mcand_q <= ld_a;
				prod_q  <= {{W{1'b0}}, ld_b};
				neg_q   <= ld_neg;
				ucap_q  <= ld_u;
				dvd_q   <= {ph_q, {F{1'b0}}};
				rem_q   <= '0;
				quo_q   <= '0;
				over_q  <= 1'b0;
			end
			skf_pkg::S_MUL: prod_q <= {mul_sum, prod_q[W-1:1]};
			skf_pkg::S_DIV: begin
				rem_q  <= ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
				dvd_q  <= {dvd_q[W+F-2:0], 1'b0};
				quo_q  <= {quo_q[W-2:0], ge};
				// a quotient bit falling off the top is an integer part too big
				over_q <= over_q | quo_q[W-1];
			end
			skf_pkg::S_POST: begin
				unique case (op_q)
					skf_pkg::OP_XP:  xp_q    <= sres;
					skf_pkg::OP_A2:  a2_q    <= mres;
					skf_pkg::OP_PP:  pp_q    <= usat;
					skf_pkg::OP_PH:  ph_q    <= mres;
					skf_pkg::OP_DEN: den_q   <= usat;
					skf_pkg::OP_DIV: g_q     <= gmag;
					skf_pkg::OP_HX:  innov_q <= sat_f(innov_w);
					skf_pkg::OP_GH:  fac_q   <= fac_pos ? fac_w[W-1:0] : '0;
					default: ;
				endcase
			end
			skf_pkg::S_OUT: if (!m_tvalid_q || m_tready) begin
				out_est_q <= est_q;
				out_var_q <= var_q;
			end
			default: ;
		endcase
	end

	assign s_tready = (state_q == skf_pkg::S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_W'({out_var_q, out_est_q});

`ifndef SYNTHESIS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == skf_pkg::S_LOAD && op_q == skf_pkg::OP_XP)
		else $error("accepted item did not start the sequence");

	a_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == skf_pkg::S_MUL || state_q == skf_pkg::S_DIV |-> cnt_q != '0)
		else $error("step counter ran out inside a multiply or divide");

	a_gain_capped: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == skf_pkg::S_POST && op_q == skf_pkg::OP_DIV |=> !g_q[W-1])
		else $error("gain magnitude above signed max");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == skf_pkg::S_OUT))
		else $error("result shown without finishing the sequence");

	a_out_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> m_tdata[W-1:0] == est_q)
		else $error("output estimate differs from filter state");
`endif

endmodule

[tb/sv/scalar_kalman_filter_core_tb.sv]
`timescale 1ns / 100ps

module scalar_kalman_filter_core_tb;

	localparam int FB = skf_pkg::FRAC_BITS_DEF;
	localparam int DW = skf_pkg::DATA_WIDTH_DEF;
	localparam int IDX_W = skf_pkg::REG_IDX_W;
	localparam int IN_W = ((DW + 7) / 8) * 8;
	localparam int OUT_W = ((2 * DW + 7) / 8) * 8;
	localparam int NUM_REGS = 6;
	localparam int CLK_PERIOD = 10;
	localparam int MAX_WAIT = 12;
	localparam int DRAIN_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_PHASES = 18;

	localparam logic [63:0] U_MAX = (64'd1 << DW) - 1;
	localparam logic [63:0] S_MAX = (64'd1 << (DW - 1)) - 1;
	localparam logic [63:0] S_MIN_MAG = 64'd1 << (DW - 1);
	localparam longint SMAX_L = (longint'(1) << (DW - 1)) - 1;
	localparam longint SMIN_L = -(longint'(1) << (DW - 1));
	localparam longint ONE_L = longint'(1) << FB;
	localparam logic [DW-1:0] ONE_Q = 1 << FB;
	localparam logic [DW-1:0] POS_MAX = S_MAX[DW-1:0];
	localparam logic [DW-1:0] NEG_MAX = S_MIN_MAG[DW-1:0];
	localparam logic [DW-1:0] ALL_ONES = U_MAX[DW-1:0];

	typedef struct packed {
		logic [DW-1:0] error_variance;
		logic [DW-1:0] filtered_estimate;
	} kf_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;    // measurement
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;        // filtered_estimate, error_variance
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_idx = '0;
	logic [DW-1:0] cfg_data = '0;

	// filter registers and state as the block should hold them
	logic [DW-1:0] kf_regs [NUM_REGS];
	longint est_state;
	logic [63:0] var_state;

	logic [DW-1:0] meas_q [$];
	kf_out_t pending_results [$];
	int meas_gap = 0;
	int out_stall = 0;
	int stall_draw;
	int unsigned meas_issued = 0;
	int unsigned results_seen = 0;
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles = 0;
	bit idle_on = 1'b1;

	scalar_kalman_filter_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic [63:0] abs64(input longint v);
		logic [63:0] m;
		m = v;
		if (v < 0) m = -m;
		return m;
	endfunction

	function automatic longint clamp_s(input longint v);
		if (v > SMAX_L) return SMAX_L;
		if (v < SMIN_L) return SMIN_L;
		return v;
	endfunction

	// (a*b) >> FB on magnitudes, clamped to cap
	function automatic logic [63:0] qmul_mag(input logic [63:0] a, b, cap);
		logic [127:0] prod;
		prod = ({64'd0, a} * {64'd0, b}) >> FB;
		return (prod > {64'd0, cap}) ? cap : prod[63:0];
	endfunction

	function automatic longint qmul_signed(input longint a, b);
		logic neg;
		logic [63:0] m;
		neg = (a < 0) != (b < 0);
		m = qmul_mag(abs64(a), abs64(b), neg ? S_MIN_MAG : S_MAX);
		return neg ? -longint'(m) : longint'(m);
	endfunction

	// truncated (n << FB) / d, clamped to cap
	function automatic logic [63:0] qdiv_mag(input logic [63:0] n, d, cap);
		logic [127:0] quo;
		quo = ({64'd0, n} << FB) / {64'd0, d};
		return (quo > {64'd0, cap}) ? cap : quo[63:0];
	endfunction

	function automatic void reload_state();
		est_state = longint'($signed(kf_regs[skf_pkg::REG_INIT_EST]));
		var_state = {32'd0, kf_regs[skf_pkg::REG_INIT_VAR]};
	endfunction

	function automatic void reset_filter_model();
		kf_regs[skf_pkg::REG_INIT_EST] = '0;
		kf_regs[skf_pkg::REG_INIT_VAR] = ONE_Q;
		kf_regs[skf_pkg::REG_PNOISE] = (ONE_Q + 5) / 10;
		kf_regs[skf_pkg::REG_MNOISE] = DW'(400) << FB;
		kf_regs[skf_pkg::REG_TRANS] = ONE_Q;
		kf_regs[skf_pkg::REG_OBS] = ONE_Q;
		reload_state();
	endfunction

	// predict and update for one measurement, queues the expected output
	function automatic void filter_step(input logic [DW-1:0] meas);
		longint a, h, z, xp, hx, innov, corr, gain, gh, fac;
		logic [63:0] q, r, h_mag, a2, pp, ph_mag, den, g_mag, fac_mag, pn;
		kf_out_t res;
		a = longint'($signed(kf_regs[skf_pkg::REG_TRANS]));
		h = longint'($signed(kf_regs[skf_pkg::REG_OBS]));
		q = {32'd0, kf_regs[skf_pkg::REG_PNOISE]};
		r = {32'd0, kf_regs[skf_pkg::REG_MNOISE]};
		z = longint'($signed(meas));
		h_mag = abs64(h);

		xp = qmul_signed(a, est_state);
		a2 = qmul_mag(abs64(a), abs64(a), U_MAX);
		pp = qmul_mag(a2, var_state, U_MAX) + q;
		if (pp > U_MAX) pp = U_MAX;

		ph_mag = qmul_mag(pp, h_mag, U_MAX);
		den = qmul_mag(ph_mag, h_mag, U_MAX) + r;
		if (den > U_MAX) den = U_MAX;
		g_mag = (den == 0) ? 64'd0 : qdiv_mag(ph_mag, den, S_MAX);
		gain = (h < 0) ? -longint'(g_mag) : longint'(g_mag);

		hx = qmul_signed(h, xp);
		innov = clamp_s(z - hx);
		corr = qmul_signed(gain, innov);
		est_state = clamp_s(xp + corr);

		// variance goes to zero once the gain fully trusts the measurement
		gh = qmul_signed(gain, h);
		fac = ONE_L - gh;
		fac_mag = fac;
		pn = (fac <= 0) ? 64'd0 : qmul_mag(fac_mag, pp, U_MAX);
		var_state = pn;

		res.filtered_estimate = est_state[DW-1:0];
		res.error_variance = var_state[DW-1:0];
		pending_results.push_back(res);
	endfunction

	task automatic note_mismatch(input string what, input logic [63:0] want_v, got_v);
		if (mismatch_count < 10)
			$display("mismatch in %s at result %0d: expected %h got %h",
				what, results_seen, want_v, got_v);
		mismatch_count++;
	endtask

	task automatic check_result(input logic [OUT_W-1:0] word);
		kf_out_t got, want;
		got = word[2*DW-1:0];
		results_seen++;
		if (pending_results.size() == 0) begin
			note_mismatch("unexpected item", '0, {32'd0, got.filtered_estimate});
		end else begin
			want = pending_results.pop_front();
			if (got.filtered_estimate !== want.filtered_estimate)
				note_mismatch("filtered_estimate", want.filtered_estimate,
					got.filtered_estimate);
			if (got.error_variance !== want.error_variance)
				note_mismatch("error_variance", want.error_variance, got.error_variance);
		end
	endtask

	// measurement driver: gap before each item counts only while the block waits
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			meas_gap <= 0;
		end else begin
			if (s_tvalid && s_tready)
				filter_step(s_tdata[DW-1:0]);
			if (!s_tvalid || s_tready) begin
				if (meas_gap != 0 || meas_q.size() == 0) begin
					s_tvalid <= 1'b0;
					if (meas_gap != 0 && s_tready)
						meas_gap <= meas_gap - 1;
				end else begin
					s_tvalid <= 1'b1;
					s_tdata <= meas_q.pop_front();
					meas_gap <= idle_on ? int'($urandom_range(0, MAX_WAIT)) : 0;
				end
			end
		end
	end

	// result monitor: stall counts only while a result is offered
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			out_stall <= 0;
		end else if (m_tvalid && m_tready) begin
			check_result(m_tdata);
			stall_draw = idle_on ? int'($urandom_range(0, MAX_WAIT)) : 0;
			out_stall <= stall_draw;
			m_tready <= (stall_draw == 0);
		end else if (m_tvalid && !m_tready) begin
			if (out_stall <= 1)
				m_tready <= 1'b1;
			else
				out_stall <= out_stall - 1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// leaves cfg_we high; the caller lowers it after the last write
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DW-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx < NUM_REGS) begin
			kf_regs[idx] = val;
			if (idx == skf_pkg::REG_INIT_EST || idx == skf_pkg::REG_INIT_VAR)
				reload_state();
		end
	endtask

	task automatic queue_meas(input logic [DW-1:0] val);
		meas_q.push_back(val);
		meas_issued++;
	endtask

	task automatic wait_drained();
		while (results_seen < meas_issued)
			@(posedge clk);
	endtask

	function automatic logic [DW-1:0] pick_coef();
		unique case ($urandom_range(0, 11))
			0: return POS_MAX;
			1: return NEG_MAX;
			2: return '0;
			3: return $urandom();
			4: return -(ONE_Q + DW'($urandom_range(0, 1 << FB)));
			default: return ONE_Q + DW'($urandom_range(0, 1 << FB)) - (ONE_Q >> 1);
		endcase
	endfunction

	function automatic logic [DW-1:0] pick_noise();
		unique case ($urandom_range(0, 9))
			0: return '0;
			1: return ALL_ONES;
			2: return $urandom();
			3: return $urandom_range(0, 1 << FB);
			default: return $urandom_range(0, 1 << 26);
		endcase
	endfunction

	function automatic logic [DW-1:0] pick_meas(input int center);
		unique case ($urandom_range(0, 15))
			0: return $urandom();
			1: return POS_MAX;
			2: return NEG_MAX;
			default: return center + int'($urandom_range(0, 1 << 22)) - (1 << 21);
		endcase
	endfunction

	initial begin
		int center;
		int n_items;
		reset_filter_model();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults, extremes of the measurement
		queue_meas('0);
		queue_meas(POS_MAX);
		queue_meas(NEG_MAX);
		queue_meas(ONE_Q);
		queue_meas(-ONE_Q);
		queue_meas(DW'(1));
		wait_drained();

		// saturation everywhere
		write_reg(skf_pkg::REG_INIT_EST, POS_MAX);
		write_reg(skf_pkg::REG_INIT_VAR, ALL_ONES);
		write_reg(skf_pkg::REG_PNOISE, ALL_ONES);
		write_reg(skf_pkg::REG_MNOISE, '0);
		write_reg(skf_pkg::REG_TRANS, NEG_MAX);
		write_reg(skf_pkg::REG_OBS, POS_MAX);
		cfg_we <= 1'b0;
		queue_meas(NEG_MAX);
		queue_meas(POS_MAX);
		queue_meas('0);
		queue_meas(ALL_ONES);
		wait_drained();

		write_reg(skf_pkg::REG_INIT_EST, NEG_MAX);
		write_reg(skf_pkg::REG_INIT_VAR, '0);
		write_reg(skf_pkg::REG_PNOISE, '0);
		write_reg(skf_pkg::REG_MNOISE, ALL_ONES);
		write_reg(skf_pkg::REG_TRANS, POS_MAX);
		write_reg(skf_pkg::REG_OBS, NEG_MAX);
		cfg_we <= 1'b0;
		queue_meas(POS_MAX);
		queue_meas(NEG_MAX);
		wait_drained();

		// zero denominator gives zero gain
		write_reg(skf_pkg::REG_OBS, '0);
		write_reg(skf_pkg::REG_MNOISE, '0);
		cfg_we <= 1'b0;
		queue_meas(ONE_Q * 5);
		queue_meas(-ONE_Q);
		wait_drained();

		// unity gain drives the variance factor to zero
		write_reg(skf_pkg::REG_TRANS, ONE_Q);
		write_reg(skf_pkg::REG_OBS, ONE_Q);
		write_reg(skf_pkg::REG_PNOISE, ONE_Q);
		write_reg(skf_pkg::REG_MNOISE, '0);
		write_reg(skf_pkg::REG_INIT_VAR, ONE_Q);
		cfg_we <= 1'b0;
		queue_meas(ONE_Q * 3);
		queue_meas(-ONE_Q * 7);
		wait_drained();

		// writes past the last register must change nothing
		for (int k = NUM_REGS; k < (1 << IDX_W); k++)
			write_reg(IDX_W'(k), ALL_ONES);
		cfg_we <= 1'b0;
		queue_meas(ONE_Q);
		queue_meas(ALL_ONES);
		wait_drained();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			idle_on = (ph % 4) != 3;
			write_reg(skf_pkg::REG_TRANS, pick_coef());
			write_reg(skf_pkg::REG_OBS, pick_coef());
			write_reg(skf_pkg::REG_PNOISE, pick_noise());
			write_reg(skf_pkg::REG_MNOISE, pick_noise());
			// some phases carry the state over from the previous one
			if ($urandom_range(0, 2) != 0) begin
				write_reg(skf_pkg::REG_INIT_EST, $urandom_range(0, 1) ? $urandom() : '0);
				write_reg(skf_pkg::REG_INIT_VAR, pick_noise());
			end
			cfg_we <= 1'b0;
			center = int'($urandom_range(0, 1 << 28)) - (1 << 27);
			n_items = $urandom_range(60, 140);
			for (int i = 0; i < n_items; i++)
				queue_meas(pick_meas(center));
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

[sim.f]
sv/skf_pkg.sv
sv/scalar_kalman_filter_core.sv
tb/sv/scalar_kalman_filter_core_tb.sv
